@@ rtl/ins_sort_pkg.sv @@
// ----------------------------------------------------------------------------
// ins_sort_pkg: shared types and constants of the insertion sorter
// Field widths, list capacity, item types and the control groups that pass
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ins_sort_pkg;

    localparam int MAX_LEN    = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    // One extra bit so that a full store can be counted.
    localparam int COUNT_W    = ADDR_W + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         end_of_list;
        logic                         overflowed;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_emit;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               emitting;
    } t_seq_status;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SHIFT   = 5'b00010,
        S_PLACE   = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

endpackage

@@ rtl/ins_sort_ram.sv @@
// ----------------------------------------------------------------------------
// ins_sort_ram: simple dual-port synchronous RAM
// One write port and one read port with a registered read; the read data
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module ins_sort_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ins_sort_seq.sv @@
// ----------------------------------------------------------------------------
// ins_sort_seq: insertion and read-out sequencer
// Walks the stored list downward from its top, moving each larger entry up
// by one place per cycle, then writes the new value into the gap. On the
// final item of a list it reads the store out in ascending order.
// ----------------------------------------------------------------------------
module ins_sort_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  ins_sort_pkg::t_in_item          i_in_item,
    output logic                            o_in_stall,
    input  logic                            i_out_free,
    input  logic [ins_sort_pkg::DATA_WIDTH-1:0] i_rdata,
    output ins_sort_pkg::t_ram_req          o_ram_req,
    output ins_sort_pkg::t_emit             o_emit,
    output ins_sort_pkg::t_seq_status       o_status
);

    import ins_sort_pkg::*;

    t_state                       r_state, n_state;
    logic [COUNT_W-1:0]           r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic signed [DATA_WIDTH-1:0] r_val, n_val;
    logic                         r_last, n_last;
    logic [ADDR_W-1:0]            r_pos, n_pos;
    logic [ADDR_W-1:0]            r_k, n_k;
    logic signed [DATA_WIDTH-1:0] rd_val;
    logic                         finish;

    assign rd_val = $signed(i_rdata);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_val     = r_val;
        n_last    = r_last;
        n_pos     = r_pos;
        n_k       = r_k;
        finish    = 1'b0;
        o_ram_req = '0;
        o_emit    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_count == COUNT_W'(MAX_LEN)) begin
                        n_ovf = 1'b1;
                        if (i_in_item.is_last) begin
                            n_state = S_EMIT_RD;
                        end
                    end else if (r_count == '0) begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = '0;
                        o_ram_req.wdata = i_in_item.value;
                        n_count         = COUNT_W'(1);
                        if (i_in_item.is_last) begin
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        n_val           = i_in_item.value;
                        n_last          = i_in_item.is_last;
                        n_pos           = r_count[ADDR_W-1:0];
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = ADDR_W'(r_count - COUNT_W'(1));
                        n_state         = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // The read data is the entry just below the gap at r_pos.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_pos;
                if (rd_val > r_val) begin
                    o_ram_req.wdata = i_rdata;
                    n_pos           = r_pos - ADDR_W'(1);
                    if (r_pos == ADDR_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_pos - ADDR_W'(2);
                    end
                end else begin
                    o_ram_req.wdata = r_val;
                    finish          = 1'b1;
                end
            end
            S_PLACE: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = '0;
                o_ram_req.wdata = r_val;
                finish          = 1'b1;
            end
            S_EMIT_RD: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = '0;
                n_k             = '0;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.load                   = 1'b1;
                    o_emit.item.sorted_value      = rd_val;
                    o_emit.item.overflowed        = r_ovf;
                    o_emit.item.end_of_list       =
                        ({1'b0, r_k} + COUNT_W'(1)) == r_count;
                    if (o_emit.item.end_of_list) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_k + ADDR_W'(1);
                        n_k             = r_k + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_count = r_count + COUNT_W'(1);
            n_state = r_last ? S_EMIT_RD : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_last <= n_last;
        r_pos  <= n_pos;
        r_k    <= n_k;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_status.count    = r_count;
    assign o_status.emitting = (r_state == S_EMIT) || (r_state == S_EMIT_RD);

endmodule

@@ rtl/insertion_sorter_core.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_core: streaming insertion sort of signed lists
// Channel   Direction  Payload      Handshake
// in        input      t_in_item    i_in_valid / o_in_stall
// out       output     t_out_item   o_out_valid / i_out_stall
// An item is written straight into an empty store and dropped when the store
// is already full; otherwise the top entry is read, each larger entry moves
// up one place, and the item is written into the gap, as the store has only
// one read port and one write port.
// After the final item of a list the first entry is read, then one result
// per cycle while out is not stalled. Reset clears the count, the overflow
// flag and the output valid; the store contents are never cleared.
// ----------------------------------------------------------------------------
module insertion_sorter_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  ins_sort_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output ins_sort_pkg::t_out_item o_out_item,
    input  logic                    i_out_stall
);

    import ins_sort_pkg::*;

    t_ram_req              ram_req;
    t_emit                 emit;
    t_seq_status           status;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  out_free;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    assign out_free = !r_out_valid || !i_out_stall;

    ins_sort_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    ins_sort_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_rdata    (rdata),
        .o_ram_req  (ram_req),
        .o_emit     (emit),
        .o_status   (status)
    );

    // Output register: it holds each sorted item while out is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_item <= emit.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= COUNT_W'(MAX_LEN))
        else $error("held count exceeds capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.emitting |-> o_in_stall)
        else $error("input taken during read-out");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.load && emit.item.end_of_list) |=> (status.count == '0))
        else $error("count not cleared after list end");
`endif

endmodule

@@ tb/insertion_sorter_core_tb.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_core_tb: self-checking bench for the streaming sorter
// Lists of signed values go in one item at a time, and every sorted list that
// comes out is checked field by field against a model of the ordered store.
// A short table of hand-picked lists runs first, then full and overflowing
// lists, then random lists, with random gaps on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module insertion_sorter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ins_sort_pkg::*;

    localparam int IDLE_PCT   = 23;
    localparam int ITEM_GOAL  = 320;
    localparam int HANG_LIMIT = 2000;
    localparam int DRAIN      = 100;
    localparam int N_PLAN     = 25;

    localparam logic signed [DATA_WIDTH-1:0] V_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] V_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        bit                           last;
        bit                           typed;
        logic signed [DATA_WIDTH-1:0] want;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall = 1'b0;

    // Model of the block: the ordered store, its fill level and the lost flag.
    logic signed [DATA_WIDTH-1:0] ordered_list [MAX_LEN];
    int        held_n;
    bit        list_lost;
    t_out_item sorted_due [$];

    int  n_items_in;
    int  n_sorted_out;
    int  n_lists;
    int  n_lost_lists;
    int  fails;
    int  quiet_cycles;
    bit  calm;

    t_plan_row plan_tbl [N_PLAN];

    insertion_sorter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Inserts one accepted value into the model and, at the end of a list,
    // queues the whole sorted list. A typed row supplies its single result.
    function automatic void sort_into_list(t_in_item it, bit typed,
                                           logic signed [DATA_WIDTH-1:0] want);
        logic signed [DATA_WIDTH-1:0] v;
        int        pos;
        t_out_item res;
        v = it.value;
        if (held_n < MAX_LEN) begin
            pos = held_n;
            // Strictly greater only, so a repeated value lands after its equals.
            while (pos > 0 && ordered_list[pos-1] > v) begin
                ordered_list[pos] = ordered_list[pos-1];
                pos--;
            end
            ordered_list[pos] = v;
            held_n++;
        end else begin
            list_lost = 1'b1;
        end
        if (it.is_last) begin
            if (typed) begin
                res.sorted_value = want;
                res.end_of_list  = 1'b1;
                res.overflowed   = 1'b0;
                sorted_due.push_back(res);
            end else begin
                for (int k = 0; k < held_n; k++) begin
                    res.sorted_value = ordered_list[k];
                    res.end_of_list  = (k == held_n - 1);
                    res.overflowed   = list_lost;
                    sorted_due.push_back(res);
                end
            end
            if (list_lost) n_lost_lists++;
            n_lists++;
            held_n    = 0;
            list_lost = 1'b0;
        end
    endfunction

    task automatic send_item(input logic signed [DATA_WIDTH-1:0] v, input bit last,
                             input bit typed, input logic signed [DATA_WIDTH-1:0] want);
        t_in_item it;
        it.value   = v;
        it.is_last = last;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sort_into_list(it, typed, want);
        n_items_in++;
    endtask

    // Mostly full-range values, with small values for repeats and the extremes.
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        logic signed [DATA_WIDTH-1:0] v;
        case ($urandom_range(9))
            5, 6:    v = $signed($urandom_range(16)) - 8;
            7: begin
                case ($urandom_range(3))
                    0:       v = V_MIN;
                    1:       v = V_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            8:       v = $urandom_range(1) ? V_MIN + $urandom_range(3)
                                           : V_MAX - $urandom_range(3);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_list(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(pick_value(), k == len - 1, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : sorted_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_sorted_out++;
            if (sorted_due.size() == 0) begin
                $error("unexpected result: sorted_value=%0d end_of_list=%0b overflowed=%0b",
                       o_out_item.sorted_value, o_out_item.end_of_list,
                       o_out_item.overflowed);
                fails++;
            end else begin
                want = sorted_due.pop_front();
                if (o_out_item.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, o_out_item.sorted_value);
                    fails++;
                end
                if (o_out_item.end_of_list !== want.end_of_list) begin
                    $error("end_of_list: expected %0b, got %0b",
                           want.end_of_list, o_out_item.end_of_list);
                    fails++;
                end
                if (o_out_item.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, o_out_item.overflowed);
                    fails++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("insertion_sorter_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        plan_tbl = '{
            '{V_MIN,           1'b1, 1'b1, V_MIN},
            '{V_MAX,           1'b1, 1'b1, V_MAX},
            '{32'sd0,          1'b1, 1'b1, 32'sd0},
            '{-32'sd1,         1'b1, 1'b1, -32'sd1},
            '{32'sh5A5A_A5A5,  1'b1, 1'b1, 32'sh5A5A_A5A5},
            // Repeats and both extremes in one list.
            '{32'sd5,          1'b0, 1'b0, '0},
            '{-32'sd3,         1'b0, 1'b0, '0},
            '{32'sd5,          1'b0, 1'b0, '0},
            '{V_MAX,           1'b0, 1'b0, '0},
            '{V_MIN,           1'b0, 1'b0, '0},
            '{32'sd0,          1'b0, 1'b0, '0},
            '{-32'sd3,         1'b1, 1'b0, '0},
            // Descending: every item moves the whole store.
            '{32'sd40,         1'b0, 1'b0, '0},
            '{32'sd30,         1'b0, 1'b0, '0},
            '{32'sd20,         1'b0, 1'b0, '0},
            '{32'sd10,         1'b0, 1'b0, '0},
            '{-32'sd10,        1'b1, 1'b0, '0},
            // Ascending: every item lands on top.
            '{-32'sd10,        1'b0, 1'b0, '0},
            '{32'sd10,         1'b0, 1'b0, '0},
            '{32'sd20,         1'b0, 1'b0, '0},
            '{32'sd30,         1'b0, 1'b0, '0},
            '{32'sd40,         1'b1, 1'b0, '0},
            '{32'sd7,          1'b0, 1'b0, '0},
            '{32'sd7,          1'b0, 1'b0, '0},
            '{32'sd7,          1'b1, 1'b0, '0}
        };
        held_n    = 0;
        list_lost = 1'b0;
        calm      = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_tbl[r]) begin
            send_item(plan_tbl[r].value, plan_tbl[r].last, plan_tbl[r].typed,
                      plan_tbl[r].want);
        end

        // A store filled exactly, then lists whose tail, last item included,
        // is dropped.
        send_list(MAX_LEN);
        send_list(MAX_LEN + 1);
        send_list(MAX_LEN + 3);

        for (int lst = 0; n_items_in < ITEM_GOAL; lst++) begin
            calm = (lst >= 4 && lst < 10);
            send_list(($urandom_range(19) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 4)
                                                : $urandom_range(1, 16));
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Sent %0d items in %0d lists (%0d overflowed); checked %0d sorted results.",
                 n_items_in, n_lists, n_lost_lists, n_sorted_out);
        if (fails == 0) begin
            $display("insertion_sorter_core test passed");
        end else begin
            $display("insertion_sorter_core test failed");
        end
        $finish;
    end
endmodule

@@ insertion_sorter_core.f @@
rtl/ins_sort_pkg.sv
rtl/ins_sort_ram.sv
rtl/ins_sort_seq.sv
rtl/insertion_sorter_core.sv
tb/insertion_sorter_core_tb.sv
